// ===== src/cse_pkg.sv =====
// ----------------------------------------------------------------------------
// Cosine similarity engine package
// Shared widths, controller states and command/status types.
// ----------------------------------------------------------------------------
package cse_pkg;

  localparam int unsigned ElemBits = 16;
  localparam int unsigned AccBits  = 44;
  localparam int unsigned MaxLen   = 4096;
  localparam int unsigned CntBits  = $clog2(MaxLen + 1);
  localparam int unsigned ProdBits = 2 * AccBits;       // na * nb
  localparam int unsigned CmpBits  = ProdBits + 30;     // prod * t*t, target
  localparam int unsigned MagBits  = 15;
  localparam logic signed [15:0] SimMinusOne = 16'sh8000;

  typedef enum logic [2:0] {
    ST_ACC,     // accumulate pairs
    ST_PROD,    // settle the sums, start the products
    ST_MUL,     // norm product and dot square, one partial product per cycle
    ST_SEARCH,  // form the trial for one magnitude bit
    ST_CHECK,   // compare trial against target
    ST_OUT      // load result into the output register
  } state_e;

  typedef struct packed {
    logic acc_en;
    logic prod_en;
    logic mul_en;
    logic trial_en;
    logic check_en;
    logic load;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic bit_done;
    logic mul_done;
    logic zero;
  } status_t;

endpackage

// ===== src/cse_if.sv =====
// ----------------------------------------------------------------------------
// Cosine similarity stream interfaces
// Valid/ready channels for element pairs and results.
// ----------------------------------------------------------------------------
interface cse_in_if (input logic clk_i);
  logic                      valid;
  logic                      ready;
  logic signed [15:0]        a_elem;
  logic signed [15:0]        b_elem;
  logic                      last_elem;
  modport source (output valid, a_elem, b_elem, last_elem, input ready);
  modport sink   (input valid, a_elem, b_elem, last_elem, output ready);
endinterface

interface cse_out_if (input logic clk_i);
  logic                      valid;
  logic                      ready;
  logic signed [15:0]        similarity;
  logic                      zero_norm;
  logic                      length_overflow;
  modport source (output valid, similarity, zero_norm, length_overflow, input ready);
  modport sink   (input valid, similarity, zero_norm, length_overflow, output ready);
endinterface

// ===== src/cosine_similarity_engine_top.sv =====
// Sequence: after the last pair is taken the sums settle, the four 22x22 partial
// products are summed, each of the 15 magnitude bits is tried and checked, and
// the output register is loaded; a zero norm result skips products and search.
// Throughput: one pair per cycle while accumulating; the next vector streams in
// while a result waits, and a new result waits until the previous one has gone.
// Reset: asynchronous active-low rst_ni clears all sums, count and state.
// ----------------------------------------------------------------------------
// Cosine similarity engine top level
// Streams element pairs and returns one Q1.15 cosine per vector.
// ----------------------------------------------------------------------------
module cosine_similarity_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  cse_in_if.sink      in_if,
  cse_out_if.source   out_if
);

  cse_pkg::cmd_t    cmd;
  cse_pkg::status_t sts;

  cse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_last_i   (in_if.last_elem),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cse_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .a_elem_i     (in_if.a_elem),
    .b_elem_i     (in_if.b_elem),
    .sts_o        (sts),
    .similarity_o (out_if.similarity),
    .zero_norm_o  (out_if.zero_norm),
    .overflow_o   (out_if.length_overflow)
  );

endmodule

// ===== src/cse_datapath.sv =====
// ----------------------------------------------------------------------------
// Cosine similarity datapath
// Accumulators, multi-cycle products, bit-serial magnitude search and the
// output register.
// ----------------------------------------------------------------------------
module cse_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cse_pkg::cmd_t        cmd_i,
  input  logic signed [15:0]   a_elem_i,
  input  logic signed [15:0]   b_elem_i,
  output cse_pkg::status_t     sts_o,
  output logic signed [15:0]   similarity_o,
  output logic                 zero_norm_o,
  output logic                 overflow_o
);

  localparam int unsigned AW = cse_pkg::AccBits;
  localparam int unsigned HW = AW / 2;
  localparam int unsigned CW = cse_pkg::CmpBits;
  localparam logic signed [AW-1:0] SMax = {1'b0, {(AW-1){1'b1}}};
  localparam logic signed [AW-1:0] SMin = {1'b1, {(AW-1){1'b0}}};
  localparam logic [AW-1:0] UMax = {AW{1'b1}};

  logic signed [AW-1:0] dot_q;
  logic [AW-1:0] na_q, nb_q;
  logic [cse_pkg::CntBits-1:0] cnt_q;
  logic ovf_q;
  logic signed [31:0] pab_q;
  logic [31:0] paa_q, pbb_q;
  logic prd_v_q;
  logic [cse_pkg::ProdBits-1:0] prod_q;
  logic [CW-1:0] target_q, trial_q, pm2_q, pm_q;
  logic neg_q;
  logic [cse_pkg::MagBits-1:0] mag_q;
  logic [3:0] bit_q;
  logic [1:0] ph_q;
  logic signed [15:0] sim_d, sim_q;
  logic zero_q, ovf_out_q;
  logic signed [AW+1:0] dot_sum;
  logic [AW:0] na_sum, nb_sum;
  logic [AW-1:0] dmag;
  logic [HW-1:0] na_part, nb_part, da_part, db_part;
  logic [AW-1:0] pp, dd;
  logic [5:0] pp_sh;
  logic [cse_pkg::MagBits-1:0] try_m;
  logic ok;

  // Saturating sums of registered products
  assign dot_sum = {{2{dot_q[AW-1]}}, dot_q} + (AW+2)'(pab_q);
  assign na_sum  = {1'b0, na_q} + (AW+1)'(paa_q);
  assign nb_sum  = {1'b0, nb_q} + (AW+1)'(pbb_q);
  assign dmag    = dot_q[AW-1] ? AW'(-dot_q) : dot_q;
  assign try_m   = mag_q | (cse_pkg::MagBits'(1) << bit_q);
  assign ok      = neg_q ? (trial_q < target_q) : (trial_q <= target_q);

  // Partial products: phase bit 0 picks the half of the first operand, bit 1 the second
  assign na_part = ph_q[0] ? na_q[AW-1:HW] : na_q[HW-1:0];
  assign nb_part = ph_q[1] ? nb_q[AW-1:HW] : nb_q[HW-1:0];
  assign da_part = ph_q[0] ? dmag[AW-1:HW] : dmag[HW-1:0];
  assign db_part = ph_q[1] ? dmag[AW-1:HW] : dmag[HW-1:0];
  assign pp      = na_part * nb_part;
  assign dd      = da_part * db_part;
  assign pp_sh   = (ph_q[0] ? 6'(HW) : 6'd0) + (ph_q[1] ? 6'(HW) : 6'd0);

  // Element products, one register stage before the adders
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prd_v_q <= 1'b0;
    end else begin
      prd_v_q <= cmd_i.acc_en && (cnt_q < cse_pkg::CntBits'(cse_pkg::MaxLen));
    end
  end

  always_ff @(posedge clk_i) begin
    pab_q <= a_elem_i * b_elem_i;
    paa_q <= 32'(a_elem_i * a_elem_i);
    pbb_q <= 32'(b_elem_i * b_elem_i);
  end

  // Accumulate, count and clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0; na_q <= '0; nb_q <= '0; cnt_q <= '0; ovf_q <= 1'b0;
    end else if (cmd_i.clear) begin
      dot_q <= '0; na_q <= '0; nb_q <= '0; cnt_q <= '0; ovf_q <= 1'b0;
    end else begin
      if (cmd_i.acc_en) begin
        if (cnt_q >= cse_pkg::CntBits'(cse_pkg::MaxLen)) ovf_q <= 1'b1;
        else cnt_q <= cnt_q + 1'b1;
      end
      if (prd_v_q) begin
        if (dot_sum > (AW+2)'(SMax)) dot_q <= SMax;
        else if (dot_sum < (AW+2)'(SMin)) dot_q <= SMin;
        else dot_q <= dot_sum[AW-1:0];
        na_q <= na_sum[AW] ? UMax : na_sum[AW-1:0];
        nb_q <= nb_sum[AW] ? UMax : nb_sum[AW-1:0];
      end
    end
  end

  // Products accumulated from partial products, then search prod * m*m against dot^2 << 30.
  // prod * t*t is built from running prod * m*m and prod * m with shifts and adds.
  always_ff @(posedge clk_i) begin
    if (cmd_i.prod_en) begin
      prod_q   <= '0;
      target_q <= '0;
      pm2_q    <= '0;
      pm_q     <= '0;
      neg_q    <= dot_q[AW-1];
      mag_q    <= '0;
      bit_q    <= 4'd14;
      ph_q     <= 2'd0;
    end
    if (cmd_i.mul_en) begin
      prod_q   <= prod_q + (cse_pkg::ProdBits'(pp) << pp_sh);
      target_q <= target_q + (CW'(dd) << (7'(pp_sh) + 7'd30));
      ph_q     <= ph_q + 2'd1;
    end
    if (cmd_i.trial_en) begin
      trial_q <= pm2_q + (pm_q << (bit_q + 5'd1)) + (CW'(prod_q) << {bit_q, 1'b0});
    end
    if (cmd_i.check_en) begin
      if (ok) begin
        mag_q <= try_m;
        pm2_q <= trial_q;
        pm_q  <= pm_q + (CW'(prod_q) << bit_q);
      end
      bit_q <= bit_q - 1'b1;
    end
  end

  assign sim_d = sts_o.zero ? cse_pkg::SimMinusOne :
                 neg_q ? -$signed({1'b0, mag_q}) - 16'sd1 : $signed({1'b0, mag_q});

  // Output register, loaded as the sums are cleared
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sim_q     <= '0;
      zero_q    <= 1'b0;
      ovf_out_q <= 1'b0;
    end else if (cmd_i.load) begin
      sim_q     <= sim_d;
      zero_q    <= sts_o.zero;
      ovf_out_q <= ovf_q;
    end
  end

  assign sts_o.bit_done = (bit_q == 4'd0);
  assign sts_o.mul_done = (ph_q == 2'd3);
  assign sts_o.zero     = (na_q == '0) || (nb_q == '0);
  assign similarity_o   = sim_q;
  assign zero_norm_o    = zero_q;
  assign overflow_o     = ovf_out_q;

endmodule

// ===== src/cse_ctrl.sv =====
// ----------------------------------------------------------------------------
// Cosine similarity controller
// Sequences accumulation, the magnitude search and the result transaction.
// ----------------------------------------------------------------------------
module cse_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  cse_pkg::status_t   sts_i,
  output cse_pkg::cmd_t      cmd_o
);

  cse_pkg::state_e state_q, state_d;
  logic wait_q, wait_d;
  logic out_v_q, out_v_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cse_pkg::ST_ACC;
      wait_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
      out_v_q <= out_v_d;
    end
  end

  assign out_valid_o = out_v_q;

  // Next state and commands
  always_comb begin
    state_d     = state_q;
    wait_d      = 1'b0;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_v_d     = out_v_q;
    case (state_q)
      cse_pkg::ST_ACC: begin
        in_ready_o   = 1'b1;
        cmd_o.acc_en = in_valid_i;
        if (in_valid_i && in_last_i) state_d = cse_pkg::ST_PROD;
      end
      cse_pkg::ST_PROD: begin
        // let the last product land in the sums first
        wait_d = 1'b1;
        if (wait_q) begin
          cmd_o.prod_en = 1'b1;
          state_d = sts_i.zero ? cse_pkg::ST_OUT : cse_pkg::ST_MUL;
        end
      end
      cse_pkg::ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        if (sts_i.mul_done) state_d = cse_pkg::ST_SEARCH;
      end
      cse_pkg::ST_SEARCH: begin
        cmd_o.trial_en = 1'b1;
        state_d = cse_pkg::ST_CHECK;
      end
      cse_pkg::ST_CHECK: begin
        cmd_o.check_en = 1'b1;
        state_d = sts_i.bit_done ? cse_pkg::ST_OUT : cse_pkg::ST_SEARCH;
      end
      cse_pkg::ST_OUT: begin
        // load once the previous result has gone
        if (!out_v_q || out_ready_i) begin
          cmd_o.load  = 1'b1;
          cmd_o.clear = 1'b1;
          state_d = cse_pkg::ST_ACC;
        end
      end
      default: state_d = cse_pkg::ST_ACC;
    endcase
    // Hold the result until its transaction
    if (cmd_o.load) out_v_d = 1'b1;
    else if (out_ready_i) out_v_d = 1'b0;
  end

endmodule

// ===== src/cse_checker.sv =====
// ----------------------------------------------------------------------------
// Cosine similarity port checker
// Checks result transactions against the handshake seen at the ports.
// ----------------------------------------------------------------------------
module cse_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               in_last_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic signed [15:0] similarity_i,
  input logic               zero_norm_i
);

  // No pair is taken in the cycle after a last pair
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && in_last_i) |=> !in_ready_i)
    else $error("pair taken straight after last");

  // A zero norm result reads as -1.0
  a_zero_minus_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && zero_norm_i) |-> (similarity_i == -16'sd32768))
    else $error("zero norm without -1.0");

  // Handshake outputs are always known
  a_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({in_ready_i, out_valid_i}))
    else $error("handshake output unknown");

  // A stalled result holds its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(similarity_i) && $stable(zero_norm_i)))
    else $error("result changed while stalled");

endmodule

bind cosine_similarity_engine_top cse_checker u_cse_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if.valid),
  .in_ready_i   (in_if.ready),
  .in_last_i    (in_if.last_elem),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .similarity_i (out_if.similarity),
  .zero_norm_i  (out_if.zero_norm)
);
